FILE: hw/rtl/lspg_pkg.sv
// shared constants, types and structs of the led strip pattern generator
package lspg_pkg;

  // strip and field sizes
  localparam int LED_LIMIT = 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int COL_W     = 8;
  localparam int PCT_W     = 7;
  localparam int MODE_W    = 2;
  localparam int LVL_W     = 5;
  localparam int HUE_W     = 9;

  // effect constants
  localparam int BREATH_STEPS = 20;
  localparam int PCT_MAX      = 100;
  localparam int COL_MAX      = 255;
  localparam int HUE_DEG      = 360;
  localparam int HUE_STEP     = 2;
  localparam int HUE_FRAC     = 256;
  localparam int SEC_DEG      = 60;
  localparam int HUE_FULL     = HUE_DEG * HUE_FRAC;
  localparam int HUE_SECTOR   = SEC_DEG * HUE_FRAC;
  localparam int HPOS_W       = 17;
  localparam int SREM_W       = 14;
  localparam int SEC_W        = 3;

  // shared divider
  localparam int DVD_W     = 23;
  localparam int DVS_W     = 7;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int RIDX_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_SOLID   = 2'd0,
    MODE_BREATH  = 2'd1,
    MODE_RAINBOW = 2'd2,
    MODE_CHASE   = 2'd3
  } mode_e;

  typedef enum logic [RIDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_BASE_RED   = 3'd1,
    REG_BASE_GREEN = 3'd2,
    REG_BASE_BLUE  = 3'd3,
    REG_BRIGHTNESS = 3'd4,
    REG_NUM_LEDS   = 3'd5
  } reg_e;

  typedef struct packed {
    mode_e            mode;
    logic [COL_W-1:0] base_red;
    logic [COL_W-1:0] base_green;
    logic [COL_W-1:0] base_blue;
    logic [PCT_W-1:0] brightness_percent;
    logic [CNT_W-1:0] num_leds;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

endpackage

FILE: hw/rtl/lspg_if.sv
// stream interfaces for frame ticks in and led colours out
interface lspg_in_if
  import lspg_pkg::*;
();
  logic valid;
  logic ready;
  logic frame_tick;

  modport source (output valid, output frame_tick, input ready);
  modport sink   (input valid, input frame_tick, output ready);
endinterface

interface lspg_out_if
  import lspg_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] led_index;
  logic [COL_W-1:0] red;
  logic [COL_W-1:0] green;
  logic [COL_W-1:0] blue;
  logic             frame_last;

  modport source (output valid, output led_index, output red, output green, output blue,
                  output frame_last, input ready);
  modport sink   (input valid, input led_index, input red, input green, input blue,
                  input frame_last, output ready);
endinterface

FILE: hw/rtl/lspg_cfg.sv
// apb-style configuration register file
module lspg_cfg
  import lspg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e ridx;
  logic wr_en;

  assign ridx   = reg_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (ridx)
        REG_MODE:       cfg_d.mode               = mode_e'(pwdata[MODE_W-1:0]);
        REG_BASE_RED:   cfg_d.base_red           = pwdata[COL_W-1:0];
        REG_BASE_GREEN: cfg_d.base_green         = pwdata[COL_W-1:0];
        REG_BASE_BLUE:  cfg_d.base_blue          = pwdata[COL_W-1:0];
        REG_BRIGHTNESS: cfg_d.brightness_percent = pwdata[PCT_W-1:0];
        REG_NUM_LEDS:   cfg_d.num_leds           = pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_MODE:       prdata = DATA_W'(cfg_q.mode);
      REG_BASE_RED:   prdata = DATA_W'(cfg_q.base_red);
      REG_BASE_GREEN: prdata = DATA_W'(cfg_q.base_green);
      REG_BASE_BLUE:  prdata = DATA_W'(cfg_q.base_blue);
      REG_BRIGHTNESS: prdata = DATA_W'(cfg_q.brightness_percent);
      REG_NUM_LEDS:   prdata = DATA_W'(cfg_q.num_leds);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode               <= MODE_SOLID;
      cfg_q.base_red           <= '0;
      cfg_q.base_green         <= '0;
      cfg_q.base_blue          <= '0;
      cfg_q.brightness_percent <= PCT_W'(PCT_MAX);
      cfg_q.num_leds           <= CNT_W'(8);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: hw/rtl/lspg_div.sv
// shared restoring divider, one quotient bit per cycle
module lspg_div
  import lspg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0]     quo_q, quo_d;
  logic [DVS_W-1:0]     rem_q, rem_d;
  logic [DVS_W-1:0]     dvs_q, dvs_d;
  logic [DVS_W:0]       trial;
  logic                 fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DVD_W - 1);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
      quo_d = {quo_q[DVD_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

FILE: hw/rtl/lspg_seq.sv
// frame sequencer: effect state, divider operand selection and led output register
module lspg_seq
  import lspg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  input  logic             in_tick_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [IDX_W-1:0] led_index_o,
  output logic [COL_W-1:0] red_o,
  output logic [COL_W-1:0] green_o,
  output logic [COL_W-1:0] blue_o,
  output logic             frame_last_o,
  output div_req_t         div_req_o,
  input  div_rsp_t         div_rsp_i
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_WAIT  = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

  typedef enum logic [2:0] {
    OP_RED   = 3'd0,
    OP_GREEN = 3'd1,
    OP_BLUE  = 3'd2,
    OP_HUE   = 3'd3,
    OP_TINT  = 3'd4,
    OP_FALL  = 3'd5,
    OP_CHASE = 3'd6
  } op_e;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic              rising_q, rising_d;
  logic [HUE_W-1:0]  hue_q, hue_d;
  logic [IDX_W-1:0]  chase_q, chase_d;
  logic [COL_W-1:0]  red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [SEC_W-1:0]  sec_q, sec_d;
  logic [SREM_W-1:0] srem_q, srem_d;
  logic [COL_W-1:0]  tint_q, tint_d;

  logic [CNT_W-1:0]  n_eff;
  logic [PCT_W-1:0]  pct_eff;
  logic [LVL_W-1:0]  lvl_nx, lvl_cap;
  logic              rising_nx;
  logic [PCT_W-1:0]  scale;
  logic [COL_W-1:0]  base_sel;
  logic [HPOS_W:0]   h_sum;
  logic [HPOS_W-1:0] h_pos;
  logic [SEC_W-1:0]  h_sec;
  logic [SREM_W-1:0] h_rem;
  logic [SREM_W-1:0] fall_span;
  logic [SREM_W+COL_W-1:0] tint_prod, fall_prod;
  logic [HUE_W:0]    hue_sum;
  logic [COL_W-1:0]  quo_col;
  logic              last;
  logic              in_acc;

  // clamp led count and brightness
  always_comb begin
    if (cfg_i.num_leds == '0) n_eff = CNT_W'(1);
    else if (cfg_i.num_leds > CNT_W'(LED_LIMIT)) n_eff = CNT_W'(LED_LIMIT);
    else n_eff = cfg_i.num_leds;
    pct_eff = (cfg_i.brightness_percent > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX)
                                                             : cfg_i.brightness_percent;
  end

  // triangle ramp step of the breathing level
  always_comb begin
    lvl_cap   = (lvl_q > LVL_W'(BREATH_STEPS)) ? LVL_W'(BREATH_STEPS) : lvl_q;
    rising_nx = rising_q;
    if (rising_q) begin
      lvl_nx = lvl_q + 1'b1;
      if (lvl_nx >= LVL_W'(BREATH_STEPS)) begin
        lvl_nx    = LVL_W'(BREATH_STEPS);
        rising_nx = 1'b0;
      end
    end else begin
      lvl_nx = (lvl_cap == '0) ? '0 : lvl_cap - 1'b1;
      if (lvl_nx == '0) rising_nx = 1'b1;
    end
  end

  // hue of the current led and its sextant
  always_comb begin
    h_sum = {1'b0, hue_q, 8'b0} + (HPOS_W+1)'(div_rsp_i.quotient[HPOS_W-1:0]);
    h_pos = (h_sum >= (HPOS_W+1)'(HUE_FULL)) ? HPOS_W'(h_sum - (HPOS_W+1)'(HUE_FULL))
                                            : HPOS_W'(h_sum);
    if (h_pos >= HPOS_W'(5 * HUE_SECTOR)) begin
      h_sec = 3'd5;
      h_rem = SREM_W'(h_pos - HPOS_W'(5 * HUE_SECTOR));
    end else if (h_pos >= HPOS_W'(4 * HUE_SECTOR)) begin
      h_sec = 3'd4;
      h_rem = SREM_W'(h_pos - HPOS_W'(4 * HUE_SECTOR));
    end else if (h_pos >= HPOS_W'(3 * HUE_SECTOR)) begin
      h_sec = 3'd3;
      h_rem = SREM_W'(h_pos - HPOS_W'(3 * HUE_SECTOR));
    end else if (h_pos >= HPOS_W'(2 * HUE_SECTOR)) begin
      h_sec = 3'd2;
      h_rem = SREM_W'(h_pos - HPOS_W'(2 * HUE_SECTOR));
    end else if (h_pos >= HPOS_W'(HUE_SECTOR)) begin
      h_sec = 3'd1;
      h_rem = SREM_W'(h_pos - HPOS_W'(HUE_SECTOR));
    end else begin
      h_sec = 3'd0;
      h_rem = SREM_W'(h_pos);
    end
  end

  // divider operands; x/15360 is taken as (x/256)/60
  always_comb begin
    scale     = (cfg_i.mode == MODE_BREATH) ? PCT_W'(lvl_q) : pct_eff;
    fall_span = SREM_W'(HUE_SECTOR) - srem_q;
    tint_prod = {srem_q, 8'b0} - (SREM_W+COL_W)'(srem_q);
    fall_prod = {fall_span, 8'b0} - (SREM_W+COL_W)'(fall_span);
    case (op_q)
      OP_GREEN: base_sel = cfg_i.base_green;
      OP_BLUE:  base_sel = cfg_i.base_blue;
      default:  base_sel = cfg_i.base_red;
    endcase
    div_req_o.start = (state_q == S_START);
    case (op_q)
      OP_RED, OP_GREEN, OP_BLUE: begin
        div_req_o.dividend = DVD_W'(base_sel) * DVD_W'(scale);
        div_req_o.divisor  = (cfg_i.mode == MODE_BREATH) ? DVS_W'(BREATH_STEPS)
                                                         : DVS_W'(PCT_MAX);
      end
      OP_HUE: begin
        div_req_o.dividend = DVD_W'(idx_q) * DVD_W'(HUE_FULL);
        div_req_o.divisor  = n_q;
      end
      OP_TINT: begin
        div_req_o.dividend = DVD_W'(tint_prod[SREM_W+COL_W-1:8]);
        div_req_o.divisor  = DVS_W'(SEC_DEG);
      end
      OP_FALL: begin
        div_req_o.dividend = DVD_W'(fall_prod[SREM_W+COL_W-1:8]);
        div_req_o.divisor  = DVS_W'(SEC_DEG);
      end
      default: begin
        div_req_o.dividend = DVD_W'(chase_q) + DVD_W'(1);
        div_req_o.divisor  = n_q;
      end
    endcase
  end

  assign quo_col = div_rsp_i.quotient[COL_W-1:0];
  assign last    = ((CNT_W'(idx_q) + 1'b1) == n_q);
  assign in_acc  = in_valid_i && (state_q == S_IDLE);
  assign hue_sum = {1'b0, hue_q} + (HUE_W+1)'(HUE_STEP);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    idx_d    = idx_q;
    n_d      = n_q;
    lvl_d    = lvl_q;
    rising_d = rising_q;
    hue_d    = hue_q;
    chase_d  = chase_q;
    red_d    = red_q;
    green_d  = green_q;
    blue_d   = blue_q;
    sec_d    = sec_q;
    srem_d   = srem_q;
    tint_d   = tint_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_tick_i) begin
          n_d   = n_eff;
          idx_d = '0;
          case (cfg_i.mode)
            MODE_SOLID: begin
              op_d    = OP_RED;
              state_d = S_START;
            end
            MODE_BREATH: begin
              lvl_d    = lvl_nx;
              rising_d = rising_nx;
              op_d     = OP_RED;
              state_d  = S_START;
            end
            MODE_RAINBOW: begin
              op_d    = OP_HUE;
              state_d = S_START;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_START: state_d = S_WAIT;
      S_WAIT: begin
        if (div_rsp_i.done) begin
          case (op_q)
            OP_RED: begin
              red_d   = quo_col;
              op_d    = OP_GREEN;
              state_d = S_START;
            end
            OP_GREEN: begin
              green_d = quo_col;
              op_d    = OP_BLUE;
              state_d = S_START;
            end
            OP_BLUE: begin
              blue_d  = quo_col;
              state_d = S_OUT;
            end
            OP_HUE: begin
              sec_d   = h_sec;
              srem_d  = h_rem;
              op_d    = OP_TINT;
              state_d = S_START;
            end
            OP_TINT: begin
              tint_d  = quo_col;
              op_d    = OP_FALL;
              state_d = S_START;
            end
            OP_FALL: begin
              // full-saturation hsv sextants, fall value is the quotient
              case (sec_q)
                3'd0: begin red_d = COL_W'(COL_MAX); green_d = tint_q; blue_d = '0; end
                3'd1: begin red_d = quo_col; green_d = COL_W'(COL_MAX); blue_d = '0; end
                3'd2: begin red_d = '0; green_d = COL_W'(COL_MAX); blue_d = tint_q; end
                3'd3: begin red_d = '0; green_d = quo_col; blue_d = COL_W'(COL_MAX); end
                3'd4: begin red_d = tint_q; green_d = '0; blue_d = COL_W'(COL_MAX); end
                default: begin red_d = COL_W'(COL_MAX); green_d = '0; blue_d = quo_col; end
              endcase
              state_d = S_OUT;
            end
            default: begin
              chase_d = div_rsp_i.remainder[IDX_W-1:0];
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (last) begin
            case (cfg_i.mode)
              MODE_RAINBOW: begin
                hue_d   = (hue_sum >= (HUE_W+1)'(HUE_DEG))
                          ? HUE_W'(hue_sum - (HUE_W+1)'(HUE_DEG)) : HUE_W'(hue_sum);
                state_d = S_IDLE;
              end
              MODE_CHASE: begin
                op_d    = OP_CHASE;
                state_d = S_START;
              end
              default: state_d = S_IDLE;
            endcase
          end else begin
            idx_d = idx_q + 1'b1;
            if (cfg_i.mode == MODE_RAINBOW) begin
              op_d    = OP_HUE;
              state_d = S_START;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= OP_RED;
      idx_q    <= '0;
      n_q      <= CNT_W'(1);
      lvl_q    <= '0;
      rising_q <= 1'b1;
      hue_q    <= '0;
      chase_q  <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      idx_q    <= idx_d;
      n_q      <= n_d;
      lvl_q    <= lvl_d;
      rising_q <= rising_d;
      hue_q    <= hue_d;
      chase_q  <= chase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
    sec_q   <= sec_d;
    srem_q  <= srem_d;
    tint_q  <= tint_d;
  end

  // chase lights only the led at the travelling position
  always_comb begin
    if (cfg_i.mode == MODE_CHASE) begin
      if (idx_q == chase_q) begin
        red_o   = cfg_i.base_red;
        green_o = cfg_i.base_green;
        blue_o  = cfg_i.base_blue;
      end else begin
        red_o   = '0;
        green_o = '0;
        blue_o  = '0;
      end
    end else begin
      red_o   = red_q;
      green_o = green_q;
      blue_o  = blue_q;
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign led_index_o  = idx_q;
  assign frame_last_o = last;

endmodule

FILE: hw/rtl/led_strip_pattern_generator.sv
// top level of the led strip pattern generator
//
//   port            dir   handshake            payload
//   tick_i          in    valid/ready          frame_tick
//   led_o           out   valid/ready          led_index, red, green, blue, frame_last
//   apb (psel...)   in    psel/penable/pready  paddr, pwdata, prdata
//
// a tick transaction with frame_tick low is taken while idle and changes nothing
// solid and breathing: three divider passes per frame, then one led a cycle while led_o.ready
// is high; rainbow: three divider passes per led; chase: one led a cycle while led_o.ready
// is high, then one divider pass for the position wrap on the 23-step shared divider
// tick_i.ready is low for the whole frame; a stalled led_o holds its colour and index
// rst_ni clears control and effect phases at once, no clearing pass
module led_strip_pattern_generator
  import lspg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  lspg_in_if.sink           tick_i,
  lspg_out_if.source        led_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // register file; the user must write it only between frames, the block does not enforce this
  lspg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // shared divider: colour scaling, hue spread, sextant ramps and chase wrap
  lspg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer owns the effect phases and the led output register
  lspg_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (tick_i.valid),
    .in_tick_i    (tick_i.frame_tick),
    .in_ready_o   (tick_i.ready),
    .out_valid_o  (led_o.valid),
    .out_ready_i  (led_o.ready),
    .led_index_o  (led_o.led_index),
    .red_o        (led_o.red),
    .green_o      (led_o.green),
    .blue_o       (led_o.blue),
    .frame_last_o (led_o.frame_last),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp)
  );

endmodule
